@@ src/tlam_pkg.sv @@
// Shared types, constants and the sine table builder for the tremolo block.
package tlam_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int SINE_DEPTH    = 1024;
  localparam int SINE_IDX_BITS = $clog2(SINE_DEPTH);
  localparam int LFO_BITS      = 17;
  localparam int DEPTH_BITS    = 17;
  localparam int GAIN_BITS     = 33;
  localparam int PROD_BITS     = SAMPLE_BITS + GAIN_BITS;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [LFO_BITS-1:0]   FULL_Q16  = LFO_BITS'(65536);
  localparam logic [LFO_BITS-1:0]   HALF_Q16  = LFO_BITS'(32768);
  localparam logic [GAIN_BITS-1:0]  FULL_GAIN = GAIN_BITS'(64'h1_0000_0000);
  localparam logic [31:0]           EDGE_FALL = 32'd2061584302;
  localparam logic [31:0]           EDGE_RISE = 32'd4209067950;
  localparam logic [31:0]           QUARTER   = 32'h4000_0000;
  localparam logic [31:0]           THREE_Q   = 32'hC000_0000;
  localparam logic [31:0]           HALF_TURN = 32'h8000_0000;

  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;

  typedef enum logic [1:0] {
    SHAPE_TRIANGLE = 2'd0,
    SHAPE_SQUARE   = 2'd1,
    SHAPE_SLOPED   = 2'd2,
    SHAPE_SINE     = 2'd3
  } shape_t;

  typedef enum logic [1:0] {
    REG_SHAPE = 2'd0,
    REG_DEPTH = 2'd1,
    REG_STEP  = 2'd2,
    REG_NONE  = 2'd3
  } reg_index_t;

  typedef logic [SINE_DEPTH-1:0][LFO_BITS-1:0] sine_rom_t;

  typedef struct packed {
    logic        en;
    logic        advance;
    shape_t      shape;
    logic [31:0] step;
  } lfo_ctrl_t;

  // One entry of 0.5 + 0.5 sin, Taylor series in Q30 folded to the first quadrant.
  function automatic logic [LFO_BITS-1:0] sine_entry(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        mag;
    logic signed [63:0] sum;
    logic               neg;
    x   = (64'(k) * TWO_PI_Q30) / 64'(SINE_DEPTH);
    neg = 1'b0;
    if (x >= PI_Q30) begin
      x   = x - PI_Q30;
      neg = 1'b1;
    end
    if (x > HALF_PI_Q30) begin
      x = PI_Q30 - x;
    end
    term = x;
    sum  = $signed(x);
    for (int n = 1; n <= 7; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    mag = (64'(sum) + 64'd16384) >> 15;
    if (mag > 64'd32768) begin
      mag = 64'd32768;
    end
    return neg ? LFO_BITS'(64'd32768 - mag) : LFO_BITS'(64'd32768 + mag);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      rom[k] = sine_entry(k);
    end
    return rom;
  endfunction

endpackage

@@ src/tremolo_lfo_amplitude_modulator.sv @@
// Top level of the stereo tremolo: configuration, gain stage, two lanes and output register.
// The block takes one stereo word per clock while the output side is not stalling and
// returns one modulated stereo word for each. The accepting edge loads v0, first of five
// register stages; the word then passes v1, v2, v3 to m_tvalid. A word enters
// when s_tvalid and s_tready are high; the LFO phase seen by that word is the value before
// its own update, and the phase then advances by phase_step. The latency comes from the
// pipeline: waveform lookup, the depth times LFO multiply that forms the gain, the
// magnitude capture, the sample times gain multiply in each lane, and the output register
// where both lanes merge. The whole pipeline halts while a finished word waits at the
// output, so s_tready simply follows the output side. The sine table is a constant table
// built at elaboration, so there is no clearing pass after reset. The user must write
// configuration via cfg_we, cfg_index and cfg_data only while no word is in flight; the
// block does not enforce it. Depth above full scale is full depth; unused-index writes drop.
module tremolo_lfo_amplitude_modulator import tlam_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [2*SAMPLE_BITS-1:0]   s_tdata,   // sample_left, sample_right
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [2*SAMPLE_BITS-1:0]   m_tdata,   // out_left, out_right
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [CFG_DATA_BITS-1:0]   cfg_data
);

  shape_t                 lfo_shape;
  logic [DEPTH_BITS-1:0]  depth_q16;
  logic [31:0]            phase_step;

  logic                   en;
  logic                   accept;
  lfo_ctrl_t              lfo_ctrl;
  logic [LFO_BITS-1:0]    lfo_q16;

  logic                   v0;
  logic                   v1;
  logic                   v2;
  logic                   v3;
  logic [SAMPLE_BITS-1:0] left0;
  logic [SAMPLE_BITS-1:0] right0;
  logic [SAMPLE_BITS-1:0] left1;
  logic [SAMPLE_BITS-1:0] right1;
  logic [GAIN_BITS-1:0]   gain;
  logic [DEPTH_BITS-1:0]  depth_eff;
  logic [GAIN_BITS:0]     swing;
  logic signed [SAMPLE_BITS-1:0] lane_left;
  logic signed [SAMPLE_BITS-1:0] lane_right;

  // The pipeline moves whenever the output register is empty or being emptied.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lfo_shape  <= SHAPE_SQUARE;
      depth_q16  <= DEPTH_BITS'(32768);
      phase_step <= 32'd89478;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_SHAPE: lfo_shape  <= shape_t'(cfg_data[1:0]);
        REG_DEPTH: depth_q16  <= cfg_data[DEPTH_BITS-1:0];
        REG_STEP:  phase_step <= cfg_data[31:0];
        REG_NONE:  ;
        default:   ;
      endcase
    end
  end

  assign lfo_ctrl = '{en: en, advance: accept, shape: lfo_shape, step: phase_step};

  tlam_lfo u_lfo (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (lfo_ctrl),
    .lfo_q16 (lfo_q16)
  );

  // Gain in Q32 is one minus depth times the LFO value.
  assign depth_eff = (depth_q16 > FULL_Q16) ? FULL_Q16 : depth_q16;
  assign swing     = (GAIN_BITS+1)'(depth_eff) * (GAIN_BITS+1)'(lfo_q16);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0       <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v0       <= s_tvalid;
      v1       <= v0;
      v2       <= v1;
      v3       <= v2;
      m_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      left0  <= s_tdata[SAMPLE_BITS-1:0];
      right0 <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
      left1  <= left0;
      right1 <= right0;
      gain   <= GAIN_BITS'((GAIN_BITS+1)'(FULL_GAIN) - swing);
    end
  end

  tlam_lane u_lane_left (
    .clk    (clk),
    .en     (en),
    .sample (left1),
    .gain   (gain),
    .result (lane_left)
  );

  tlam_lane u_lane_right (
    .clk    (clk),
    .en     (en),
    .sample (right1),
    .gain   (gain),
    .result (lane_right)
  );

  // Merge both lanes into the output word.
  always_ff @(posedge clk) begin
    if (en && v3) begin
      m_tdata <= {lane_right, lane_left};
    end
  end

  a_accept_enters : assert property (@(posedge clk) disable iff (rst)
    accept |=> v0)
    else $error("accepted word did not enter the pipeline");

  a_lfo_range : assert property (@(posedge clk) disable iff (rst)
    v1 |-> (lfo_q16 <= FULL_Q16 || !v1) && swing <= (GAIN_BITS+1)'(FULL_GAIN))
    else $error("gain swing exceeds full scale");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable({v0, v1, v2, v3}))
    else $error("pipeline moved while output was stalled");

endmodule

@@ src/tlam_lfo.sv @@
// LFO phase accumulator and waveform generator with a registered Q16 output.
module tlam_lfo import tlam_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  lfo_ctrl_t           ctrl,
  output logic [LFO_BITS-1:0] lfo_q16
);

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  logic [31:0]         phase;
  logic [31:0]         tri_off;
  logic [32:0]         slope_off;
  logic [32:0]         slope_prod;
  logic [LFO_BITS-1:0] lfo_next;
  logic [LFO_BITS-1:0] wave_q;
  logic [LFO_BITS-1:0] sine_q;
  logic                sine_sel;

  always_comb begin
    tri_off    = 32'd0;
    slope_off  = 33'd0;
    slope_prod = 33'd0;
    lfo_next   = '0;
    unique case (ctrl.shape)
      SHAPE_TRIANGLE: begin
        if (phase < QUARTER) begin
          lfo_next = HALF_Q16 + LFO_BITS'(phase[31:15]);
        end else if (phase < THREE_Q) begin
          tri_off  = phase - QUARTER;
          lfo_next = FULL_Q16 - LFO_BITS'(tri_off[31:15]);
        end else begin
          tri_off  = phase - THREE_Q;
          lfo_next = LFO_BITS'(tri_off[31:15]);
        end
      end
      SHAPE_SQUARE: begin
        lfo_next = (phase < HALF_TURN) ? FULL_Q16 : '0;
      end
      SHAPE_SLOPED: begin
        // Falling edge between 0.48 and 0.5, rising edge from 0.98 to the wrap.
        if (phase < EDGE_FALL) begin
          lfo_next = FULL_Q16;
        end else if (phase < HALF_TURN) begin
          slope_off  = 33'(phase - EDGE_FALL);
          slope_prod = 33'(slope_off * 33'd50);
          lfo_next   = FULL_Q16 - LFO_BITS'(slope_prod[32:16]);
        end else if (phase < EDGE_RISE) begin
          lfo_next = '0;
        end else begin
          slope_off  = 33'(phase - EDGE_RISE);
          slope_prod = 33'(slope_off * 33'd50);
          lfo_next   = LFO_BITS'(slope_prod[32:16]);
        end
      end
      SHAPE_SINE: begin
        // The sine table is read in its own register below.
        lfo_next = '0;
      end
      default: lfo_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (ctrl.advance) begin
      phase <= phase + ctrl.step;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      wave_q   <= lfo_next;
      sine_q   <= SINE_ROM[phase[31 -: SINE_IDX_BITS]];
      sine_sel <= (ctrl.shape == SHAPE_SINE);
    end
  end

  assign lfo_q16 = sine_sel ? sine_q : wave_q;

endmodule

@@ src/tlam_lane.sv @@
// One channel lane: magnitude, gain multiply, rounding and saturation.
module tlam_lane import tlam_pkg::*; (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [GAIN_BITS-1:0]          gain,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam logic [SAMPLE_BITS:0] SAT_NEG = (SAMPLE_BITS+1)'(1) << (SAMPLE_BITS - 1);
  localparam logic [SAMPLE_BITS:0] SAT_POS = SAT_NEG - (SAMPLE_BITS+1)'(1);

  logic [SAMPLE_BITS-1:0] mag;
  logic [GAIN_BITS-1:0]   gain_r;
  logic                   neg;
  logic [PROD_BITS-1:0]   prod;
  logic                   neg_p;
  logic [PROD_BITS-1:0]   rounded;
  logic [SAMPLE_BITS:0]   r;
  logic [SAMPLE_BITS:0]   r_sat;

  always_ff @(posedge clk) begin
    if (en) begin
      neg    <= sample[SAMPLE_BITS-1];
      // Negating the most negative code gives its own pattern, the right magnitude.
      mag    <= sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);
      gain_r <= gain;
      prod   <= PROD_BITS'(mag) * PROD_BITS'(gain_r);
      neg_p  <= neg;
    end
  end

  always_comb begin
    rounded = prod + (PROD_BITS'(1) << 31);
    r       = rounded[PROD_BITS-1:32];
    if (neg_p) begin
      r_sat  = (r > SAT_NEG) ? SAT_NEG : r;
      result = SAMPLE_BITS'(-r_sat);
    end else begin
      r_sat  = (r > SAT_POS) ? SAT_POS : r;
      result = SAMPLE_BITS'(r_sat);
    end
  end

endmodule

@@ tb/sv/tremolo_lfo_amplitude_modulator_checker.sv @@
`timescale 1ns / 100ps
// Checker for the tremolo block: predicts every output word and compares it field by field.
module tremolo_lfo_amplitude_modulator_checker import tlam_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  input  logic                     s_tready,
  input  logic [2*SAMPLE_BITS-1:0] s_tdata,   // sample_left, sample_right
  input  logic                     m_tvalid,
  input  logic                     m_tready,
  input  logic [2*SAMPLE_BITS-1:0] m_tdata,   // out_left, out_right
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output int                       mismatches,
  output int                       pending,
  output int                       checked
);

  localparam logic [63:0] NEG_LIMIT = 64'd1 << (SAMPLE_BITS - 1);
  localparam logic [63:0] POS_LIMIT = NEG_LIMIT - 64'd1;

  logic [LFO_BITS-1:0]      sine_level [SINE_DEPTH];
  logic [2*SAMPLE_BITS-1:0] expected_pairs [$];

  shape_t                   shape_cfg;
  logic [DEPTH_BITS-1:0]    depth_cfg;
  logic [31:0]              step_cfg;
  logic [31:0]              lfo_phase;

  // Quarter-wave Taylor series in Q30, mirrored to build the unipolar sine level.
  function automatic logic [LFO_BITS-1:0] sine_level_at(input int unsigned k);
    logic [63:0] ang;
    logic [63:0] pw;
    logic [63:0] m;
    longint      acc;
    logic        lower_half;
    ang        = (64'(k) * TWO_PI_Q30) / 64'(SINE_DEPTH);
    lower_half = (ang >= PI_Q30);
    if (lower_half) begin
      ang = ang - PI_Q30;
    end
    if (ang > HALF_PI_Q30) begin
      ang = PI_Q30 - ang;
    end
    pw  = ang;
    acc = longint'(ang);
    for (int n = 1; n <= 7; n++) begin
      pw = (((pw * ang) >> 30) * ang) >> 30;
      pw = pw / 64'((2 * n) * (2 * n + 1));
      acc = (n % 2 == 1) ? acc - longint'(pw) : acc + longint'(pw);
    end
    if (acc < 0) begin
      acc = 0;
    end
    m = (64'(acc) + 64'd16384) >> 15;
    if (m > 64'd32768) begin
      m = 64'd32768;
    end
    return lower_half ? LFO_BITS'(64'd32768 - m) : LFO_BITS'(64'd32768 + m);
  endfunction

  function automatic logic [LFO_BITS-1:0] lfo_level(input shape_t shape, input logic [31:0] p);
    logic [63:0] q;
    q = 64'(p);
    case (shape)
      SHAPE_TRIANGLE: begin
        if (p < QUARTER) return HALF_Q16 + LFO_BITS'(p >> 15);
        else if (p < THREE_Q) return FULL_Q16 - LFO_BITS'((p - QUARTER) >> 15);
        else return LFO_BITS'((p - THREE_Q) >> 15);
      end
      SHAPE_SQUARE: begin
        return (p < HALF_TURN) ? FULL_Q16 : '0;
      end
      SHAPE_SLOPED: begin
        if (p < EDGE_FALL) return FULL_Q16;
        else if (p < HALF_TURN)
          return FULL_Q16 - LFO_BITS'(((q - 64'(EDGE_FALL)) * 64'd50) >> 16);
        else if (p < EDGE_RISE) return '0;
        else return LFO_BITS'(((q - 64'(EDGE_RISE)) * 64'd50) >> 16);
      end
      default: begin
        return sine_level[p[31 -: SINE_IDX_BITS]];
      end
    endcase
  endfunction

  // Sign-magnitude scaling with round half away from zero, then saturation.
  function automatic logic [SAMPLE_BITS-1:0] scale_sample(input logic [SAMPLE_BITS-1:0] s,
                                                          input logic [63:0] gain);
    logic [SAMPLE_BITS:0] mag;
    logic [63:0]          r;
    mag = s[SAMPLE_BITS-1] ? ({1'b0, ~s} + 1'b1) : {1'b0, s};
    r   = (64'(mag) * gain + 64'h8000_0000) >> 32;
    if (s[SAMPLE_BITS-1]) begin
      if (r > NEG_LIMIT) r = NEG_LIMIT;
      return SAMPLE_BITS'(~r + 64'd1);
    end
    if (r > POS_LIMIT) r = POS_LIMIT;
    return SAMPLE_BITS'(r);
  endfunction

  function automatic logic [2*SAMPLE_BITS-1:0] tremolo_pair(input logic [2*SAMPLE_BITS-1:0] pair);
    logic [63:0] depth_eff;
    logic [63:0] gain;
    depth_eff = (depth_cfg > FULL_Q16) ? 64'(FULL_Q16) : 64'(depth_cfg);
    gain      = 64'(FULL_GAIN) - depth_eff * 64'(lfo_level(shape_cfg, lfo_phase));
    return {scale_sample(pair[2*SAMPLE_BITS-1:SAMPLE_BITS], gain),
            scale_sample(pair[SAMPLE_BITS-1:0], gain)};
  endfunction

  initial begin
    for (int k = 0; k < SINE_DEPTH; k++) begin
      sine_level[k] = sine_level_at(k);
    end
  end

  always @(posedge clk) begin : watch
    logic [2*SAMPLE_BITS-1:0] want;
    if (rst) begin
      expected_pairs.delete();
      mismatches = 0;
      checked    = 0;
      shape_cfg  = SHAPE_SQUARE;
      depth_cfg  = HALF_Q16;
      step_cfg   = 32'd89478;
      lfo_phase  = '0;
    end else begin
      // Outputs are checked before inputs are predicted; a word accepted at this
      // edge cannot leave the block at the same edge.
      if (m_tvalid && m_tready) begin
        if (expected_pairs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Unexpected output word %h with nothing outstanding", m_tdata);
          end
        end else begin
          want = expected_pairs.pop_front();
          checked++;
          if (m_tdata[SAMPLE_BITS-1:0] !== want[SAMPLE_BITS-1:0] ||
              m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS] !== want[2*SAMPLE_BITS-1:SAMPLE_BITS]) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Word %0d: out_left expected %h got %h, out_right expected %h got %h",
                       checked, want[SAMPLE_BITS-1:0], m_tdata[SAMPLE_BITS-1:0],
                       want[2*SAMPLE_BITS-1:SAMPLE_BITS],
                       m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        expected_pairs.push_back(tremolo_pair(s_tdata));
        lfo_phase = lfo_phase + step_cfg;
      end
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_SHAPE: shape_cfg = shape_t'(cfg_data[1:0]);
          REG_DEPTH: depth_cfg = cfg_data[DEPTH_BITS-1:0];
          REG_STEP:  step_cfg  = cfg_data[31:0];
          default:   ;
        endcase
      end
    end
    pending = expected_pairs.size();
  end

endmodule

@@ tb/sv/tremolo_lfo_amplitude_modulator_test.sv @@
`timescale 1ns / 100ps
// Top of the tremolo testbench: clock, reset, stimulus, stall patterns and the verdict.
module tremolo_lfo_amplitude_modulator_test import tlam_pkg::*;;

  // The run is short; the limit sits far above the slowest legal run, where every
  // word waits out long receiver stalls and sender gaps on its way through the pipeline.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_BLOCKS = 11;
  localparam int BLOCK_WORDS   = 150;
  localparam int DRAIN_CYCLES  = 20;

  localparam logic [SAMPLE_BITS-1:0] MAX_SAMPLE = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] MIN_SAMPLE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     s_tvalid  = 1'b0;
  logic                     s_tready;
  logic [2*SAMPLE_BITS-1:0] s_tdata   = '0;  // sample_left, sample_right
  logic                     m_tvalid;
  logic                     m_tready  = 1'b0;
  logic [2*SAMPLE_BITS-1:0] m_tdata;         // out_left, out_right
  logic                     cfg_we    = 1'b0;
  logic [1:0]               cfg_index = REG_SHAPE;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

  // Idle percentages for the two sides; the stimulus changes them between blocks.
  int tx_idle_pct = 16;
  int rx_idle_pct = 70;

  int cycle_count = 0;
  int words_sent  = 0;
  int settings    = 0;
  int mismatches;
  int pending;
  int checked;

  tremolo_lfo_amplitude_modulator u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tremolo_lfo_amplitude_modulator_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  always #5 clk = ~clk;

  // The receiver decides anew at every falling edge whether it takes a word.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog: a hung handshake or a lost word ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding", cycle_count, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Presents one stereo word and holds it until the block takes it. Random idle
  // cycles come first, each lowering tvalid at its own falling edge, so tvalid is
  // never dropped and raised within one time step.
  task automatic send_pair(input logic [SAMPLE_BITS-1:0] left,
                           input logic [SAMPLE_BITS-1:0] right);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {right, left};
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  // Stops the input side and waits until every predicted word has come out.
  task automatic quiesce();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Registers are only written once the pipeline is empty.
  task automatic configure(input logic [31:0] shape_data, input logic [31:0] depth_data,
                           input logic [31:0] step_data);
    quiesce();
    write_reg(REG_SHAPE, shape_data);
    write_reg(REG_DEPTH, depth_data);
    write_reg(REG_STEP, step_data);
    settings++;
  endtask

  // Samples lean on the rails, zero and minus one, with small and full-range values.
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return MAX_SAMPLE;
      1:       return MIN_SAMPLE;
      2:       return '0;
      3:       return '1;
      4:       return SAMPLE_BITS'($signed(16'($urandom)));
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_depth();
    case ($urandom_range(5))
      0:       return 32'd0;
      1:       return 32'(FULL_Q16);
      2:       return 32'($urandom_range(65537, 131071));  // above full depth
      3:       return $urandom;                            // bits beyond the register
      default: return 32'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(4))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return 32'($urandom_range(32'h0010_0000, 32'h0400_0000));
    endcase
  endfunction

  initial begin : stimulus
    logic [31:0] shape_data;
    logic [31:0] step_data;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words. The reset settings give a square wave at half depth, and
    // the first word sees phase zero, so both rails come out at half amplitude.
    send_pair(MAX_SAMPLE, MIN_SAMPLE);
    send_pair('0, '1);
    send_pair(SAMPLE_BITS'(1), SAMPLE_BITS'(24'h555555));

    // Triangle, selected through a shape word with junk in the upper bits, and
    // a depth whose in-register value lies above full scale. A quarter-turn step
    // walks the phase over the corners of the triangle.
    configure(32'hFFFF_FFFC, 32'hFFFF_FFFF, QUARTER);
    send_pair(MIN_SAMPLE, MAX_SAMPLE);
    send_pair(MAX_SAMPLE, MAX_SAMPLE);
    send_pair(MIN_SAMPLE, MIN_SAMPLE);
    send_pair('1, SAMPLE_BITS'(1));
    send_pair(SAMPLE_BITS'(24'hAAAAAA), SAMPLE_BITS'(24'h123456));

    // A write to the unused index must leave every register alone.
    quiesce();
    write_reg(REG_NONE, 32'hFFFF_FFFF);
    configure(32'(SHAPE_SLOPED), 32'(FULL_Q16), 32'h0800_0000);
    for (int i = 0; i < 6; i++) begin
      send_pair(MAX_SAMPLE, MIN_SAMPLE);
    end

    // Sine at zero depth passes samples through; the largest step runs backward.
    configure(32'(SHAPE_SINE), 32'd0, 32'hFFFF_FFFF);
    send_pair(MAX_SAMPLE, MIN_SAMPLE);
    send_pair(SAMPLE_BITS'(24'h7A5A5A), SAMPLE_BITS'(24'h85A5A5));
    send_pair('1, '0);

    configure(32'(SHAPE_SINE), 32'(FULL_Q16), 32'h1000_0000);
    for (int i = 0; i < 4; i++) begin
      send_pair(MAX_SAMPLE, MIN_SAMPLE);
    end

    // Random blocks: each shape in turn with fresh depth and step. The first
    // blocks stall the receiver hard, the middle ones starve it, the last run
    // with both sides always ready.
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      if (blk == 4) begin
        tx_idle_pct = 70;
        rx_idle_pct = 16;
      end else if (blk == 8) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      shape_data = 32'(blk % 4);
      if ($urandom_range(1) == 1) begin
        shape_data = ($urandom & ~32'h3) | shape_data;
      end
      step_data = (blk == 0) ? 32'd0 : (blk == 1) ? 32'hFFFF_FFFF : pick_step();
      configure(shape_data, pick_depth(), step_data);
      for (int i = 0; i < BLOCK_WORDS; i++) begin
        send_pair(pick_sample(), pick_sample());
      end
    end

    quiesce();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d stereo words and checked %0d results across %0d register settings,",
             words_sent, checked, settings);
    $display("covering all four LFO shapes and three stall patterns; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/tlam_pkg.sv
src/tlam_lfo.sv
src/tlam_lane.sv
src/tremolo_lfo_amplitude_modulator.sv
tb/sv/tremolo_lfo_amplitude_modulator_checker.sv
tb/sv/tremolo_lfo_amplitude_modulator_test.sv
